// ===== rtl/tdq_pkg.sv =====
// Shared types and command/status codes for the timestamped double-ended queue.
package tdq_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NOP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REM_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ADD_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

  typedef struct packed {
    logic add_front;
    logic add_back;
    logic rem_front;
    logic rem_back;
  } tdq_op_t;

endpackage

// ===== rtl/tdq_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
interface tdq_in_if;
  logic                           valid;
  logic                           ready;
  logic [tdq_pkg::CMD_W-1:0]      cmd;
  logic [tdq_pkg::WORD_W-1:0]     value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface tdq_out_if #(
  parameter int unsigned CNT_W = 5
);
  logic                           valid;
  logic                           ready;
  logic [tdq_pkg::WORD_W-1:0]     front_value;
  logic [tdq_pkg::STAMP_W-1:0]    front_stamp;
  logic [tdq_pkg::STAMP_W-1:0]    back_stamp;
  logic [CNT_W-1:0]               entry_count;
  logic                           is_empty;
  logic [tdq_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output front_value, output front_stamp, output back_stamp,
                  output entry_count, output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input front_stamp, input back_stamp,
                  input entry_count, input is_empty, input status, output ready);
endinterface

// ===== rtl/timestamped_double_ended_queue_core.sv =====
// Timestamped double-ended queue built as a row of DEPTH shifting cells. The front entry always
// sits in cell 0: an add at the front shifts the whole row back by one, a remove at the front
// shifts it forward, and adds and removes at the back touch only the cell at the end of the
// occupied run, so every command changes the cell row in a single update. Each accepted add
// is stamped with a 32-bit sequence count that wraps. After a command is accepted, the row
// settles and the front entry and the back stamp are gathered into the result register, and
// then the result is offered; no new command is taken before that, and a stalled result
// holds off the next command. The back stamp is an OR over every cell, so its depth grows
// with log2(DEPTH). entry_count is $clog2(DEPTH+1) bits wide. No clearing pass after reset.
module timestamped_double_ended_queue_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  tdq_in_if.sink     in_ch,
  tdq_out_if.source  out_ch
);
  import tdq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                  in_beat;
  logic                  busy_r, busy_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [STAMP_W-1:0]    next_stamp_r, next_stamp_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [WORD_W-1:0]     res_front_value_r;
  logic [STAMP_W-1:0]    res_front_stamp_r;
  logic [STAMP_W-1:0]    res_back_stamp_r;
  logic [CNT_W-1:0]      res_count_r;
  logic                  res_empty_r;
  logic [STATUS_W-1:0]   res_status_r;

  tdq_op_t               op;
  logic                  row_empty;
  logic                  row_full;
  logic [DATA_WIDTH-1:0] new_data;
  logic [63:0]           in_wide;
  logic [63:0]           front_wide;
  logic [STAMP_W-1:0]    back_stamp_or;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [STAMP_W-1:0]    cell_stamp [DEPTH];
  logic                  cell_valid [DEPTH];
  logic                  cell_back  [DEPTH];

  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign in_beat     = in_ch.valid && in_ch.ready;

  assign in_wide   = 64'(in_ch.value);
  assign new_data  = in_wide[DATA_WIDTH-1:0];
  assign row_empty = !cell_valid[0];
  assign row_full  = cell_valid[DEPTH-1];

  // decode the command; illegal adds and removes reach no cell
  always_comb begin
    op         = '0;
    status_nxt = status_r;
    if (in_beat) begin
      status_nxt = ST_DONE;
      case (in_ch.cmd)
        CMD_ADD_FRONT, CMD_ADD_BACK: begin
          if (row_full) begin
            status_nxt = ST_ADD_FULL;
          end else begin
            op.add_front = (in_ch.cmd == CMD_ADD_FRONT);
            op.add_back  = (in_ch.cmd == CMD_ADD_BACK);
          end
        end
        CMD_REM_FRONT, CMD_REM_BACK: begin
          if (row_empty) begin
            status_nxt = ST_REM_EMPTY;
          end else begin
            op.rem_front = (in_ch.cmd == CMD_REM_FRONT);
            op.rem_back  = (in_ch.cmd == CMD_REM_BACK);
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_comb begin
    count_nxt      = count_r;
    next_stamp_nxt = next_stamp_r;
    if (op.add_front || op.add_back) begin
      count_nxt      = count_r + 1'b1;
      next_stamp_nxt = next_stamp_r + 1'b1;
    end else if (op.rem_front || op.rem_back) begin
      count_nxt = count_r - 1'b1;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] l_data;
      logic [STAMP_W-1:0]    l_stamp;
      logic                  l_valid;
      logic [DATA_WIDTH-1:0] r_data;
      logic [STAMP_W-1:0]    r_stamp;
      logic                  r_valid;

      if (gi == 0) begin : g_head
        assign l_data  = new_data;
        assign l_stamp = next_stamp_r;
        assign l_valid = 1'b1;
      end else begin : g_mid
        assign l_data  = cell_data[gi-1];
        assign l_stamp = cell_stamp[gi-1];
        assign l_valid = cell_valid[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign r_data  = '0;
        assign r_stamp = '0;
        assign r_valid = 1'b0;
      end else begin : g_body
        assign r_data  = cell_data[gi+1];
        assign r_stamp = cell_stamp[gi+1];
        assign r_valid = cell_valid[gi+1];
      end

      tdq_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .new_data    (new_data),
        .new_stamp   (next_stamp_r),
        .left_data   (l_data),
        .left_stamp  (l_stamp),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_stamp (r_stamp),
        .right_valid (r_valid),
        .data_q      (cell_data[gi]),
        .stamp_q     (cell_stamp[gi]),
        .valid_q     (cell_valid[gi]),
        .is_back     (cell_back[gi])
      );
    end
  endgenerate

  // exactly one cell flags itself as the back when the row holds anything
  always_comb begin
    back_stamp_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_stamp_or = back_stamp_or | (cell_back[i] ? cell_stamp[i] : '0);
    end
  end

  assign front_wide = 64'(cell_data[0]);

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_beat) begin
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
      next_stamp_r <= '0;
      status_r     <= ST_DONE;
    end else begin
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      count_r      <= count_nxt;
      next_stamp_r <= next_stamp_nxt;
      status_r     <= status_nxt;
    end
  end

  // capture the result once the row has settled
  always_ff @(posedge clk) begin
    if (busy_r) begin
      res_front_value_r <= cell_valid[0] ? front_wide[WORD_W-1:0] : '0;
      res_front_stamp_r <= cell_valid[0] ? cell_stamp[0] : '0;
      res_back_stamp_r  <= back_stamp_or;
      res_count_r       <= count_r;
      res_empty_r       <= !cell_valid[0];
      res_status_r      <= status_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = res_front_value_r;
  assign out_ch.front_stamp = res_front_stamp_r;
  assign out_ch.back_stamp  = res_back_stamp_r;
  assign out_ch.entry_count = res_count_r;
  assign out_ch.is_empty    = res_empty_r;
  assign out_ch.status      = res_status_r;

endmodule

// ===== rtl/tdq_cell.sv =====
// One slot of the queue chain: holds a word, its stamp and a valid bit.
module tdq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tdq_pkg::tdq_op_t              op,
  input  logic [DATA_WIDTH-1:0]         new_data,
  input  logic [tdq_pkg::STAMP_W-1:0]   new_stamp,
  input  logic [DATA_WIDTH-1:0]         left_data,
  input  logic [tdq_pkg::STAMP_W-1:0]   left_stamp,
  input  logic                          left_valid,
  input  logic [DATA_WIDTH-1:0]         right_data,
  input  logic [tdq_pkg::STAMP_W-1:0]   right_stamp,
  input  logic                          right_valid,
  output logic [DATA_WIDTH-1:0]         data_q,
  output logic [tdq_pkg::STAMP_W-1:0]   stamp_q,
  output logic                          valid_q,
  output logic                          is_back
);
  import tdq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r,  data_nxt;
  logic [STAMP_W-1:0]    stamp_r, stamp_nxt;
  logic                  valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    stamp_nxt = stamp_r;
    valid_nxt = valid_r;
    if (op.add_front) begin
      // shift toward the back; the head cell sees the new beat as its left neighbor
      data_nxt  = left_data;
      stamp_nxt = left_stamp;
      valid_nxt = left_valid;
    end else if (op.add_back) begin
      // only the first empty slot behind the occupied run takes the word
      if (!valid_r && left_valid) begin
        data_nxt  = new_data;
        stamp_nxt = new_stamp;
        valid_nxt = 1'b1;
      end
    end else if (op.rem_front) begin
      data_nxt  = right_data;
      stamp_nxt = right_stamp;
      valid_nxt = right_valid;
    end else if (op.rem_back) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    stamp_r <= stamp_nxt;
  end

  assign data_q  = data_r;
  assign stamp_q = stamp_r;
  assign valid_q = valid_r;
  assign is_back = valid_r && !right_valid;

endmodule

// ===== rtl/tdq_checker.sv =====
// Port-level checks for the queue core, attached by bind.
module tdq_checker #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = 5
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tdq_pkg::WORD_W-1:0]      front_value,
  input logic [tdq_pkg::STAMP_W-1:0]     front_stamp,
  input logic [tdq_pkg::STAMP_W-1:0]     back_stamp,
  input logic [CNT_W-1:0]                entry_count,
  input logic                            is_empty,
  input logic [tdq_pkg::STATUS_W-1:0]    status
);
  import tdq_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(front_value) && $stable(status))
    else $error("result beat changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> front_value == '0 && front_stamp == '0 && back_stamp == '0)
    else $error("empty result carries nonzero fields");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_count <= CNT_W'(DEPTH) && status != ST_UNUSED)
    else $error("entry count or status out of range");

  // one result per command: no new command while a result is still pending
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 out_valid)
    else $error("command accepted without its result following");

endmodule

bind timestamped_double_ended_queue_core tdq_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_tdq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .front_value (out_ch.front_value),
  .front_stamp (out_ch.front_stamp),
  .back_stamp  (out_ch.back_stamp),
  .entry_count (out_ch.entry_count),
  .is_empty    (out_ch.is_empty),
  .status      (out_ch.status)
);
